FILE: rtl/erst_pkg.sv
`timescale 1ns / 1ps
package erst_pkg;

  localparam int WHEELS  = 3;
  localparam int CNT_W   = 16;
  localparam int DELTA_W = 17;
  localparam int EL_W    = 32;
  localparam int RATE_W  = 32;
  localparam int PROD_W  = 35;
  localparam int PER_W   = 10;
  localparam int IN_W    = 80;
  localparam int OUT_W   = 248;
  localparam int CFG_IDX_W = 2;

  localparam logic [19:0]         US_PER_S    = 20'd1000000;
  localparam logic [PER_W-1:0]    PERIOD_MIN  = 10'd5;
  localparam logic [PER_W-1:0]    PERIOD_MAX  = 10'd1000;
  localparam logic [PER_W-1:0]    PERIOD_RST  = 10'd10;
  localparam logic [19:0]         MS_TO_US    = 20'd1000;
  localparam logic [EL_W-1:0]     MIN_ELAPSED = 32'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd1;

  typedef logic signed [DELTA_W-1:0] delta_t;

  typedef struct packed {
    logic                           clear;
    logic [WHEELS-1:0][DELTA_W-1:0] delta;
    logic [EL_W-1:0]                divisor;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_UPD,
    BK_DONE
  } bk_state_t;

endpackage

FILE: rtl/encoder_rate_estimator.sv
`timescale 1ns / 1ps
// With the back end idle, out_tvalid rises once a sample has passed MUL, DIV and UPD
// for each wheel, then DONE; a clear goes from IDLE straight to DONE. One sample at a
// time uses the one-bit-per-cycle divider (35 steps plus multiply and update per
// wheel, plus load and output) shared by the three wheels; a stalled result waits.
// A queue of QUEUE_DEPTH entries takes new beats while the back end works.
// Reset (rst_n low, synchronous): state and queue clear, period 10 ms, no inversion.
module encoder_rate_estimator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [0:0]                     in_tuser,   // operation
  input  logic [erst_pkg::IN_W-1:0]      in_tdata,   // count_wheel0..2, interval in us
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // delta_wheel0..2, rate_wheel0..2, total_wheel0..2, zero pad
  output logic [erst_pkg::OUT_W-1:0]     out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [erst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erst_pkg::PER_W-1:0]     cfg_data
);

  erst_pkg::q_stat_t q_stat;
  erst_pkg::entry_t  q_wdata, q_rdata;
  logic              q_push, q_pop;

  erst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  erst_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  erst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/erst_front.sv
`timescale 1ns / 1ps
module erst_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [0:0]                     in_tuser,
  input  logic [erst_pkg::IN_W-1:0]      in_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [erst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erst_pkg::PER_W-1:0]     cfg_data,
  input  erst_pkg::q_stat_t              q_stat,
  output logic                           q_push,
  output erst_pkg::entry_t               q_wdata
);

  logic [erst_pkg::PER_W-1:0]  period_r;
  logic [erst_pkg::WHEELS-1:0] invert_r;
  logic [erst_pkg::PER_W-1:0]  period_cl;
  logic [19:0]                 period_us;
  logic [erst_pkg::EL_W-1:0]   elapsed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= erst_pkg::PERIOD_RST;
      invert_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        erst_pkg::CFG_PERIOD: period_r <= cfg_data;
        erst_pkg::CFG_INVERT: invert_r <= cfg_data[erst_pkg::WHEELS-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    if (period_r < erst_pkg::PERIOD_MIN) period_cl = erst_pkg::PERIOD_MIN;
    else if (period_r > erst_pkg::PERIOD_MAX) period_cl = erst_pkg::PERIOD_MAX;
    else period_cl = period_r;
  end

  assign period_us = {10'd0, period_cl} * erst_pkg::MS_TO_US;
  assign elapsed   = in_tdata[erst_pkg::IN_W-1 -: erst_pkg::EL_W];

  always_comb begin
    logic signed [erst_pkg::DELTA_W-1:0] c;
    q_wdata.clear   = in_tuser[0];
    q_wdata.divisor = (elapsed < erst_pkg::MIN_ELAPSED) ? {12'd0, period_us} : elapsed;
    for (int i = 0; i < erst_pkg::WHEELS; i++) begin
      c = {in_tdata[i*erst_pkg::CNT_W + erst_pkg::CNT_W - 1],
           in_tdata[i*erst_pkg::CNT_W +: erst_pkg::CNT_W]};
      q_wdata.delta[i] = invert_r[i] ? -c : c;
    end
  end

endmodule

FILE: rtl/erst_queue.sv
`timescale 1ns / 1ps
module erst_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  erst_pkg::entry_t  wdata,
  input  logic              pop,
  output erst_pkg::entry_t  rdata,
  output erst_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(DEPTH);

  erst_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push, do_pop;

  assign stat.full  = (fill_r == FULL);
  assign stat.empty = (fill_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) fill_r <= fill_r + 1'b1;
      else if (do_pop && !do_push) fill_r <= fill_r - 1'b1;
    end
  end

endmodule

FILE: rtl/erst_back.sv
`timescale 1ns / 1ps
module erst_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  erst_pkg::q_stat_t          q_stat,
  input  erst_pkg::entry_t           q_rdata,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [erst_pkg::OUT_W-1:0] out_tdata
);

  localparam int DW = erst_pkg::DELTA_W;
  localparam int RW = erst_pkg::RATE_W;
  localparam int PW = erst_pkg::PROD_W;
  localparam int NW = erst_pkg::WHEELS;
  localparam logic [5:0] DIV_LAST = 6'(PW - 1);
  localparam logic [1:0] W_LAST   = 2'(NW - 1);

  erst_pkg::bk_state_t state_r, state_nxt;
  erst_pkg::entry_t    ent_r;
  logic [1:0]          w_r;
  logic [5:0]          cnt_r;
  logic [PW-1:0]       quo_r;
  logic [RW-1:0]       rem_r;
  logic signed [RW-1:0] filt_r [NW];
  logic signed [RW-1:0] tot_r  [NW];
  logic                have_r;
  logic                out_valid_r;
  logic [erst_pkg::OUT_W-1:0] out_data_r;

  logic                ld_item, ld_out, out_free;
  logic signed [DW-1:0] d_cur;
  logic [DW-1:0]       mag;
  logic [32:0]         div_sh, div_sub;
  logic                div_ge;
  logic signed [RW-1:0] rate;
  logic signed [34:0]  fsum, fadj;
  logic signed [RW-1:0] filt_new;
  logic signed [32:0]  tsum;
  logic signed [RW-1:0] tot_new;
  logic [erst_pkg::OUT_W-1:0] pack;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      erst_pkg::BK_IDLE: if (!q_stat.empty) begin
        state_nxt = q_rdata.clear ? erst_pkg::BK_DONE : erst_pkg::BK_MUL;
      end
      erst_pkg::BK_MUL: state_nxt = erst_pkg::BK_DIV;
      erst_pkg::BK_DIV: if (cnt_r == DIV_LAST) state_nxt = erst_pkg::BK_UPD;
      erst_pkg::BK_UPD: state_nxt = (w_r == W_LAST) ? erst_pkg::BK_DONE : erst_pkg::BK_MUL;
      erst_pkg::BK_DONE: if (out_free) state_nxt = erst_pkg::BK_IDLE;
      default: state_nxt = erst_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ld_item = 1'b0;
    ld_out  = 1'b0;
    case (state_r)
      erst_pkg::BK_IDLE: ld_item = !q_stat.empty;
      erst_pkg::BK_DONE: ld_out  = out_free;
      default: ;
    endcase
  end

  assign q_pop = ld_item;

  assign d_cur = $signed(ent_r.delta[w_r]);
  assign mag   = d_cur[DW-1] ? DW'(-d_cur) : DW'(d_cur);

  assign div_sh  = {rem_r, quo_r[PW-1]};
  assign div_sub = div_sh - {1'b0, ent_r.divisor};
  assign div_ge  = (div_sh >= {1'b0, ent_r.divisor});

  assign rate = d_cur[DW-1] ? -$signed(quo_r[RW-1:0]) : $signed(quo_r[RW-1:0]);

  always_comb begin
    logic signed [34:0] old35;
    old35    = 35'(filt_r[w_r]);
    fsum     = old35 + (old35 <<< 1) + 35'(rate);
    fadj     = fsum[34] ? fsum + 35'sd3 : fsum;
    filt_new = have_r ? fadj[33:2] : rate;
  end

  always_comb begin
    tsum = 33'(tot_r[w_r]) + 33'(d_cur);
    if (tsum[32] != tsum[31]) tot_new = tsum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    else tot_new = tsum[31:0];
  end

  always_comb begin
    pack = '0;
    for (int i = 0; i < NW; i++) begin
      pack[i*DW +: DW]               = ent_r.clear ? '0 : ent_r.delta[i];
      pack[NW*DW + i*RW +: RW]       = filt_r[i];
      pack[NW*(DW+RW) + i*RW +: RW]  = tot_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_item) ent_r <= q_rdata;
    if (ld_out) out_data_r <= pack;
    case (state_r)
      erst_pkg::BK_MUL: begin
        quo_r <= PW'({3'd0, mag} * erst_pkg::US_PER_S);
        rem_r <= '0;
      end
      erst_pkg::BK_DIV: begin
        quo_r <= {quo_r[PW-2:0], div_ge};
        rem_r <= div_ge ? div_sub[RW-1:0] : div_sh[RW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= erst_pkg::BK_IDLE;
      w_r         <= '0;
      cnt_r       <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NW; i++) begin
        filt_r[i] <= '0;
        tot_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ld_item) begin
        w_r <= '0;
        if (q_rdata.clear) begin
          have_r <= 1'b0;
          for (int i = 0; i < NW; i++) begin
            filt_r[i] <= '0;
            tot_r[i]  <= '0;
          end
        end
      end
      case (state_r)
        erst_pkg::BK_MUL: cnt_r <= '0;
        erst_pkg::BK_DIV: cnt_r <= cnt_r + 1'b1;
        erst_pkg::BK_UPD: begin
          filt_r[w_r] <= filt_new;
          tot_r[w_r]  <= tot_new;
          w_r         <= w_r + 1'b1;
        end
        default: ;
      endcase
      if (ld_out) begin
        out_valid_r <= 1'b1;
        if (!ent_r.clear) have_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/erst_checker.sv
`timescale 1ns / 1ps
module erst_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [erst_pkg::OUT_W-1:0] out_tdata
);

  logic [16:0] d0;
  logic signed [31:0] r0;

  assign d0 = out_tdata[16:0];
  assign r0 = $signed(out_tdata[82:51]);

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> r0 >= -32'sd32768000 && r0 <= 32'sd32768000)
    else $error("rate beyond divider range");

  a_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(d0[16] && !d0[15]))
    else $error("delta below -32768");

endmodule

bind encoder_rate_estimator erst_checker u_chk (.*);

FILE: sim/wheel_rate_checker.sv
`timescale 1ns / 1ps
module wheel_rate_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [0:0]                     in_tuser,
  input  logic [erst_pkg::IN_W-1:0]      in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [erst_pkg::OUT_W-1:0]     out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [erst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erst_pkg::PER_W-1:0]     cfg_data,
  output int                             errors,
  output int                             pending
);

  localparam longint MICROS_PER_S = 1000000;
  localparam longint MS_IN_US     = 1000;
  localparam longint SHORT_SPAN   = 1000;
  localparam longint OLD_WEIGHT   = 3;
  localparam longint IIR_DIV      = 4;

  // first member lands in the highest bits, so delta_wheel0 ends up at bit 0
  typedef struct packed {
    logic [erst_pkg::WHEELS-1:0][erst_pkg::RATE_W-1:0]  total;
    logic [erst_pkg::WHEELS-1:0][erst_pkg::RATE_W-1:0]  rate;
    logic [erst_pkg::WHEELS-1:0][erst_pkg::DELTA_W-1:0] delta;
  } speed_report_t;

  localparam int REPORT_W = $bits(speed_report_t);

  logic [erst_pkg::PER_W-1:0]         period_ms;
  logic [erst_pkg::WHEELS-1:0]        invert;
  logic signed [erst_pkg::RATE_W-1:0] smoothed [erst_pkg::WHEELS];
  logic signed [erst_pkg::RATE_W-1:0] odometer [erst_pkg::WHEELS];
  bit                                 seeded;
  speed_report_t                      awaited_reports [$];
  speed_report_t                      want;
  speed_report_t                      got;
  int                                 fails;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void clear_estimates();
    for (int w = 0; w < erst_pkg::WHEELS; w++) begin
      smoothed[w] = '0;
      odometer[w] = '0;
    end
    seeded = 1'b0;
  endfunction

  function automatic speed_report_t step_estimate(logic clear,
                                                  logic [erst_pkg::IN_W-1:0] d);
    speed_report_t                      r;
    logic [erst_pkg::PER_W-1:0]         per;
    longint                             span;
    longint                             cnt;
    longint                             dl;
    logic signed [erst_pkg::RATE_W-1:0] inst;
    r = '0;
    if (clear) begin
      clear_estimates();
      return r;
    end
    per = period_ms;
    if (per < erst_pkg::PERIOD_MIN) per = erst_pkg::PERIOD_MIN;
    if (per > erst_pkg::PERIOD_MAX) per = erst_pkg::PERIOD_MAX;
    span = {32'd0, d[erst_pkg::IN_W-1 -: erst_pkg::EL_W]};
    if (span < SHORT_SPAN) span = longint'({54'd0, per}) * MS_IN_US;
    for (int w = 0; w < erst_pkg::WHEELS; w++) begin
      cnt  = $signed(d[erst_pkg::CNT_W*w +: erst_pkg::CNT_W]);
      dl   = invert[w] ? -cnt : cnt;
      inst = clamp32(dl * MICROS_PER_S / span);
      if (seeded)
        smoothed[w] = clamp32((longint'(smoothed[w]) * OLD_WEIGHT + longint'(inst)) / IIR_DIV);
      else
        smoothed[w] = inst;
      odometer[w] = clamp32(longint'(odometer[w]) + dl);
      r.delta[w] = dl[erst_pkg::DELTA_W-1:0];
      r.rate[w]  = smoothed[w];
      r.total[w] = odometer[w];
    end
    seeded = 1'b1;
    return r;
  endfunction

  task automatic check_field(input string name, input int w, input longint exp,
                             input longint act);
    if (exp != act) begin
      $display("%0t: %s%0d mismatch, expected %0d, actual %0d", $time, name, w, exp, act);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      period_ms = erst_pkg::PERIOD_RST;
      invert    = '0;
      clear_estimates();
      awaited_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          erst_pkg::CFG_PERIOD: period_ms = cfg_data;
          erst_pkg::CFG_INVERT: invert    = cfg_data[erst_pkg::WHEELS-1:0];
          default: ;
        endcase
      end
      // compare before queuing, so a beat accepted now never matches itself
      if (out_tvalid && out_tready) begin
        got = out_tdata[REPORT_W-1:0];
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
          fails++;
        end else begin
          want = awaited_reports.pop_front();
          for (int w = 0; w < erst_pkg::WHEELS; w++) begin
            check_field("delta_wheel", w, $signed(want.delta[w]), $signed(got.delta[w]));
            check_field("rate_wheel", w, $signed(want.rate[w]), $signed(got.rate[w]));
            check_field("total_wheel", w, $signed(want.total[w]), $signed(got.total[w]));
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited_reports.push_back(step_estimate(in_tuser[0], in_tdata));
    end
    errors  <= fails;
    pending <= awaited_reports.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;
  localparam logic [erst_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [erst_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int SEGMENTS  = 5;
  localparam int SEG_ITEMS = 100;
  localparam int TAIL      = 200;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [0:0]                     in_tuser   = '0;
  logic [erst_pkg::IN_W-1:0]      in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [erst_pkg::OUT_W-1:0]     out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [erst_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [erst_pkg::PER_W-1:0]     cfg_data   = '0;
  int                             errors;
  int                             pending;
  int                             gap_pct    = 36;
  int                             stall_pct  = 72;

  encoder_rate_estimator uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  wheel_rate_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic [15:0] c0, input logic [15:0] c1,
                           input logic [15:0] c2, input logic [31:0] span);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {span, c2, c1, c0};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [erst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [erst_pkg::PER_W-1:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_count();
    case ($urandom_range(3, 0))
      0:       return 16'($urandom_range(400, 0)) - 16'd200;
      1:       return 16'($urandom());
      2:       return $urandom_range(1, 0) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom_range(3000, 0));
    endcase
  endfunction

  function automatic logic [31:0] pick_span();
    case ($urandom_range(4, 0))
      0:       return $urandom_range(999, 0);
      1:       return $urandom_range(1001, 998);
      2:       return $urandom();
      3:       return $urandom_range(50000, 1000);
      default: return $urandom_range(2000000, 1000);
    endcase
  endfunction

  function automatic logic [erst_pkg::PER_W-1:0] pick_period();
    case ($urandom_range(5, 0))
      0:       return 10'd0;
      1:       return 10'd5;
      2:       return 10'd1000;
      3:       return 10'd1023;
      default: return 10'($urandom());
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_SAMPLE, 16'h7fff, 16'h8000, 16'h0000, 32'd1000);
    send_item(OP_SAMPLE, 16'h8000, 16'h7fff, 16'h0001, 32'd0);
    send_item(OP_SAMPLE, 16'h0001, 16'hffff, 16'h3039, 32'd999);
    send_item(OP_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff, 32'hffffffff);
    send_item(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'd1);
    send_item(OP_CLEAR,  16'hffff, 16'hffff, 16'hffff, 32'hffffffff);
    send_item(OP_SAMPLE, 16'h0064, 16'hff9c, 16'h0000, 32'd1000);
    drain();
    write_reg(erst_pkg::CFG_PERIOD, 10'd0, 1'b0);
    write_reg(erst_pkg::CFG_INVERT, 10'd7, 1'b1);
    send_item(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'd0);
    send_item(OP_SAMPLE, 16'h7fff, 16'h0001, 16'h8000, 32'd999);
    drain();
    write_reg(erst_pkg::CFG_PERIOD, 10'd1023, 1'b0);
    write_reg(CFG_SPARE_LO, 10'h3ff, 1'b0);
    write_reg(CFG_SPARE_HI, 10'h3ff, 1'b1);
    send_item(OP_SAMPLE, 16'h1234, 16'hedcb, 16'h8000, 32'd500);
    send_item(OP_SAMPLE, 16'h8000, 16'h7fff, 16'h0000, 32'd0);
    drain();
    write_reg(erst_pkg::CFG_PERIOD, 10'd1000, 1'b0);
    write_reg(erst_pkg::CFG_INVERT, 10'd5, 1'b1);
    send_item(OP_SAMPLE, 16'h7fff, 16'h8000, 16'h7fff, 32'd0);
    send_item(OP_CLEAR,  16'h0000, 16'h0000, 16'h0000, 32'd0);
    send_item(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'd3);
    drain();
    write_reg(erst_pkg::CFG_PERIOD, 10'd5, 1'b0);
    write_reg(erst_pkg::CFG_INVERT, 10'd2, 1'b1);
    send_item(OP_SAMPLE, 16'h0fa0, 16'h8000, 16'hf060, 32'd0);
    send_item(OP_SAMPLE, 16'h7fff, 16'h7fff, 16'h8000, 32'd2000);
    drain();
    write_reg(erst_pkg::CFG_PERIOD, 10'd4, 1'b0);
    write_reg(erst_pkg::CFG_INVERT, 10'd0, 1'b1);
    send_item(OP_SAMPLE, 16'h0100, 16'hff00, 16'h0001, 32'd0);
    drain();
    write_reg(erst_pkg::CFG_PERIOD, 10'd1001, 1'b1);
    send_item(OP_SAMPLE, 16'h0200, 16'hfe00, 16'h7fff, 32'd998);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin gap_pct = 36; stall_pct = 72; end
        1: begin gap_pct = 72; stall_pct = 36; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        drain();
        write_reg(erst_pkg::CFG_PERIOD, pick_period(), 1'b0);
        if ($urandom_range(3, 0) == 0)
          write_reg($urandom_range(1, 0) ? CFG_SPARE_LO : CFG_SPARE_HI, 10'($urandom()), 1'b0);
        write_reg(erst_pkg::CFG_INVERT, 10'($urandom_range(7, 0)), 1'b1);
        for (int n = 0; n < SEG_ITEMS; n++)
          send_item(($urandom_range(15, 0) == 0) ? OP_CLEAR : OP_SAMPLE,
                    pick_count(), pick_count(), pick_count(), pick_span());
      end
    end

    drain();
    repeat (TAIL) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/erst_pkg.sv
rtl/erst_front.sv
rtl/erst_queue.sv
rtl/erst_back.sv
rtl/encoder_rate_estimator.sv
rtl/erst_checker.sv
sim/wheel_rate_checker.sv
sim/tb.sv
